FILE: rtl/sliding_window_average_filter_defines.svh
// ---------------------------------------------------------------------------
// Sliding window average filter: assertion macros
// Shared property wrappers. Each expects clk and arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_AVERAGE_FILTER_DEFINES_SVH
`define SLIDING_WINDOW_AVERAGE_FILTER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define SWAF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define SWAF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/swaf_pkg.sv
// ---------------------------------------------------------------------------
// Sliding window average filter package
// Types and fixed constants shared by the filter modules.
// ---------------------------------------------------------------------------
`default_nettype none

package swaf_pkg;

	localparam int SAMPLE_W   = 8;
	localparam int CHANNEL_W  = 8;
	localparam int SAMPLE_MAX = 255;

	typedef logic [SAMPLE_W-1:0]  sample_t;
	typedef logic [CHANNEL_W-1:0] channel_t;

	// channel assumed before the first transfer
	localparam channel_t LAST_CHANNEL_RESET = 8'd200;

	typedef enum logic {
		MODE_PLAIN    = 1'b0,
		MODE_WEIGHTED = 1'b1
	} mode_t;

endpackage

`default_nettype wire

FILE: rtl/sliding_window_average_filter.sv
// ---------------------------------------------------------------------------
// Sliding window average filter
// Moving average over the last TAPS samples of one channel, plain or
// weighted; a change of channel refills the window with the new sample.
// ---------------------------------------------------------------------------
//  channel   signals                                  direction
//  sample    sample_valid, sample_stall, sample,      in
//            channel
//  result    result_valid, result_stall, filtered     out
//  config    cfg_wr_en, cfg_wr_data (mode)            in
//
//  One transfer per cycle sustained unless a stalled result fills the pipeline;
//  each result is presented after its sample transfer passes the sum register,
//  then the divider register (the window register loads on the transfer itself,
//  so back-to-back samples chain). Reset clears the window, sets the last
//  channel to 200 and selects the plain mean. A stalled result is held; up to
//  three items stay in flight before sample_stall rises.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sliding_window_average_filter_defines.svh"

module sliding_window_average_filter #(
	parameter int TAPS = 5
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wr_en,
	input  wire logic               cfg_wr_data,
	input  wire logic               sample_valid,
	output logic                    sample_stall,
	input  wire swaf_pkg::sample_t  sample,
	input  wire swaf_pkg::channel_t channel,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output swaf_pkg::sample_t       filtered
);

	localparam int WSUM  = TAPS * (TAPS + 1) / 2;
	localparam int SUM_W = $clog2(swaf_pkg::SAMPLE_MAX * WSUM + 1);

	swaf_pkg::mode_t   mode_q;
	swaf_pkg::mode_t   mode_s2;
	swaf_pkg::sample_t window_q [TAPS];
	logic [SUM_W-1:0]  sum_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              out_valid_q;
	logic              ld_s2;
	logic              ld_out;
	logic              accept;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= swaf_pkg::MODE_PLAIN;
		end else if (cfg_wr_en) begin
			mode_q <= swaf_pkg::mode_t'(cfg_wr_data);
		end
	end

	// pipeline advance: a stage loads when it is empty or its contents move on
	assign ld_out       = !out_valid_q || !result_stall;
	assign ld_s2        = !valid_s2 || ld_out;
	assign sample_stall = valid_s1 && !ld_s2;
	assign accept       = sample_valid && !sample_stall;
	assign result_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!valid_s1 || ld_s2) begin
				valid_s1 <= accept;
			end
			if (ld_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ld_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	swaf_window #(
		.TAPS(TAPS)
	) u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.sample   (sample),
		.channel  (channel),
		.window_q (window_q)
	);

	swaf_sum #(
		.TAPS(TAPS)
	) u_sum (
		.clk     (clk),
		.load    (ld_s2 && valid_s1),
		.mode    (mode_q),
		.window  (window_q),
		.sum_s2  (sum_s2),
		.mode_s2 (mode_s2)
	);

	swaf_div #(
		.TAPS(TAPS)
	) u_div (
		.clk        (clk),
		.load       (ld_out && valid_s2),
		.sum        (sum_s2),
		.mode       (mode_s2),
		.filtered_q (filtered)
	);

	`SWAF_ASSERT_NOW(a_stall_full, sample_stall, valid_s1 && valid_s2 && out_valid_q && result_stall, "input stalled with a free stage")
	`SWAF_ASSERT_NEXT(a_result_src, !out_valid_q && !valid_s2, !out_valid_q, "result raised without a summed item")

endmodule

`default_nettype wire

FILE: rtl/swaf_window.sv
// ---------------------------------------------------------------------------
// Sample window
// Holds the window of recent samples and the last channel; refills the
// window on a channel change, otherwise shifts the new sample in at tap 0.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sliding_window_average_filter_defines.svh"

module swaf_window #(
	parameter int TAPS = 5
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire swaf_pkg::sample_t  sample,
	input  wire swaf_pkg::channel_t channel,
	output swaf_pkg::sample_t      window_q [TAPS]
);

	swaf_pkg::channel_t last_channel_q;
	logic               change;

	assign change = (channel != last_channel_q);

	// window and channel update on each accepted transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAPS; k++) begin
				window_q[k] <= '0;
			end
			last_channel_q <= swaf_pkg::LAST_CHANNEL_RESET;
		end else if (load) begin
			if (change) begin
				for (int k = 0; k < TAPS; k++) begin
					window_q[k] <= sample;
				end
				last_channel_q <= channel;
			end else begin
				for (int k = 1; k < TAPS; k++) begin
					window_q[k] <= window_q[k-1];
				end
				window_q[0] <= sample;
			end
		end
	end

	`SWAF_ASSERT_NEXT(a_refill, load && change, (window_q[0] == $past(sample)) && (window_q[TAPS-1] == $past(sample)), "window not refilled on channel change")
	`SWAF_ASSERT_NEXT(a_shift, load && !change, (window_q[1] == $past(window_q[0])) && (window_q[0] == $past(sample)), "window did not shift")

endmodule

`default_nettype wire

FILE: rtl/swaf_sum.sv
// ---------------------------------------------------------------------------
// Window sum stage
// Forms the plain or the weighted sum of the window and registers it with
// the mode that selects the divisor.
// ---------------------------------------------------------------------------
`default_nettype none

module swaf_sum #(
	parameter int TAPS = 5
) (
	input  wire logic             clk,
	input  wire logic             load,
	input  wire swaf_pkg::mode_t  mode,
	input  wire swaf_pkg::sample_t window [TAPS],
	output logic [$clog2(swaf_pkg::SAMPLE_MAX*(TAPS*(TAPS+1)/2)+1)-1:0] sum_s2,
	output swaf_pkg::mode_t       mode_s2
);

	localparam int WSUM  = TAPS * (TAPS + 1) / 2;
	localparam int SUM_W = $clog2(swaf_pkg::SAMPLE_MAX * WSUM + 1);

	logic [SUM_W-1:0] plain_sum;
	logic [SUM_W-1:0] weighted_sum;
	logic [SUM_W-1:0] sum;

	// plain sum and weighted sum, weight k+1 on tap k (tap 0 newest)
	always_comb begin
		plain_sum    = '0;
		weighted_sum = '0;
		for (int k = 0; k < TAPS; k++) begin
			plain_sum    = plain_sum + SUM_W'(window[k]);
			weighted_sum = weighted_sum + SUM_W'(window[k]) * SUM_W'(k + 1);
		end
		unique case (mode)
			swaf_pkg::MODE_PLAIN:    sum = plain_sum;
			swaf_pkg::MODE_WEIGHTED: sum = weighted_sum;
			default:                 sum = plain_sum;
		endcase
	end

	// stage register
	always_ff @(posedge clk) begin
		if (load) begin
			sum_s2  <= sum;
			mode_s2 <= mode;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/swaf_div.sv
// ---------------------------------------------------------------------------
// Constant divider stage
// Divides the window sum by the tap count or by the weight total with a
// reciprocal multiply, and registers the filtered value.
// ---------------------------------------------------------------------------
`default_nettype none

module swaf_div #(
	parameter int TAPS = 5
) (
	input  wire logic             clk,
	input  wire logic             load,
	input  wire logic [$clog2(swaf_pkg::SAMPLE_MAX*(TAPS*(TAPS+1)/2)+1)-1:0] sum,
	input  wire swaf_pkg::mode_t  mode,
	output swaf_pkg::sample_t     filtered_q
);

	localparam int WSUM  = TAPS * (TAPS + 1) / 2;
	localparam int SUM_W = $clog2(swaf_pkg::SAMPLE_MAX * WSUM + 1);
	// shift of sum width plus divisor bits keeps the quotient exact
	localparam int SHIFT = SUM_W + $clog2(WSUM);
	localparam int PROD_W = SUM_W + SHIFT;
	localparam logic [SHIFT-1:0] RECIP_PLAIN    = SHIFT'(((2 ** SHIFT) + TAPS - 1) / TAPS);
	localparam logic [SHIFT-1:0] RECIP_WEIGHTED = SHIFT'(((2 ** SHIFT) + WSUM - 1) / WSUM);

	logic [SHIFT-1:0]  recip;
	logic [PROD_W-1:0] prod;

	// reciprocal select and multiply
	always_comb begin
		unique case (mode)
			swaf_pkg::MODE_PLAIN:    recip = RECIP_PLAIN;
			swaf_pkg::MODE_WEIGHTED: recip = RECIP_WEIGHTED;
			default:                 recip = RECIP_PLAIN;
		endcase
		prod = PROD_W'(sum) * PROD_W'(recip);
	end

	// result register; a mean of 8-bit samples always fits 8 bits
	always_ff @(posedge clk) begin
		if (load) begin
			filtered_q <= prod[SHIFT +: swaf_pkg::SAMPLE_W];
		end
	end

endmodule

`default_nettype wire
